>>> sv/cpfv_pkg.sv
// Shared types, character codes and small arithmetic helpers for the CPF
// check-digit validator. No dependencies.
package cpfv_pkg;

  localparam int QueueDepth = 2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_DASH = 8'h2D;

  localparam logic [3:0] POS_DOT_A = 4'd3;
  localparam logic [3:0] POS_DOT_B = 4'd7;
  localparam logic [3:0] POS_DASH  = 4'd11;
  localparam logic [3:0] POS_LAST  = 4'd13;
  localparam logic [3:0] POS_MAX   = 4'd15;
  localparam logic [3:0] CPF_LEN   = 4'd14;
  localparam logic [3:0] MODULUS   = 4'd11;

  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_LENGTH = 3'd1,
    ERR_FORMAT = 3'd2,
    ERR_SAME   = 3'd3,
    ERR_CHECK1 = 3'd4,
    ERR_CHECK2 = 3'd5
  } err_t;

  // One classified character as it travels from the front to the back.
  typedef struct packed {
    logic       last;
    logic       len_ok;     // character count reaches exactly 14 here
    logic       digit_pos;  // a digit position inside the first 14
    logic       fmt_ok;     // separator or digit as expected
    logic       first;      // first digit position
    logic       tenth;      // tenth digit position
    logic [3:0] digit;
    logic [3:0] p1;         // digit times first weight, mod 11
    logic [3:0] p2;         // digit times second weight, mod 11
  } class_t;

  // Remainder by 11 of a value below 128: reciprocal estimate, then one fix.
  function automatic logic [3:0] mod11(input logic [6:0] x);
    logic [13:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 14'(x) * 14'd93;
    q    = prod[13:10];
    r    = x - 7'(q) * 7'(MODULUS);
    if (r >= 7'(MODULUS)) begin
      r = r - 7'(MODULUS);
    end
    return r[3:0];
  endfunction

  // Check digit from the residue of the weighted sum: (10*r) mod 11, ten as zero.
  function automatic logic [3:0] check_of(input logic [3:0] r);
    logic [3:0] c;
    if (r <= 4'd1) begin
      c = 4'd0;
    end else begin
      c = MODULUS - r;
    end
    return c;
  endfunction

endpackage

>>> sv/cpf_check_digit_validator.sv
// CPF check-digit validator, top level: front classifier, queue and back.
// Depends on cpfv_pkg, cpfv_front, cpfv_queue and cpfv_back.
//
// Usage: the input stream carries one ASCII character of a number written as
// ddd.ddd.ddd-dd per request, with s_tlast on its final character. For every
// request with s_tlast set the block returns one verdict on the output stream:
// valid_res is 1 when the number passed every check, and error_code gives the
// first failing check (length, format, all digits equal, first check digit,
// second check digit). Requests without s_tlast give no output.
// Throughput: one character per cycle, sustained while the queue is not full. The
// front writes the classified character into the queue at acceptance; the back
// folds it into the residues when it pops it from the queue and, on the last
// character, loads the verdict register, which raises m_tvalid.
// A stalled receiver holds the verdict; characters keep flowing until the
// last character of a second number reaches the head of the queue and the
// queue (QUEUE_DEPTH entries) fills behind it, and then s_tready drops.
// Reset clears the counters, residues and queue, and the block takes a
// character in the first cycle after reset.
module cpf_check_digit_validator import cpfv_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] character
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] valid_res, [3:1] error_code, [7:4] zero
);

  class_t entry;
  class_t q_data;
  logic   push;
  logic   pop;
  logic   q_valid;
  logic   q_full;

  cpfv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .entry    (entry)
  );

  cpfv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_data    (q_data)
  );

  cpfv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> sv/cpfv_front.sv
// Front part: accepts characters, tracks position and digit index, and
// classifies each character. Depends on cpfv_pkg.
module cpfv_front import cpfv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] character
  input  logic       s_tlast,
  input  logic       q_full,
  output logic       push,
  output class_t     entry
);

  logic [3:0] char_position;
  logic [3:0] digit_index;
  logic [3:0] char_position_next;
  logic [3:0] digit_index_next;
  logic       is_digit;
  logic [3:0] d;
  logic [3:0] w1;
  logic [3:0] w2;
  logic       in_range;
  logic       sep_pos;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    in_range = char_position < CPF_LEN;
    is_digit = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    d        = is_digit ? 4'(s_tdata - CHAR_ZERO) : 4'd0;
    w1       = (digit_index < 4'd9)  ? 4'(4'd10 - digit_index) : 4'd0;
    w2       = (digit_index < 4'd10) ? 4'(4'd11 - digit_index) : 4'd0;
    sep_pos  = (char_position == POS_DOT_A) || (char_position == POS_DOT_B) ||
               (char_position == POS_DASH);

    entry.last      = s_tlast;
    entry.len_ok    = (char_position == POS_LAST);
    entry.digit_pos = in_range && !sep_pos;
    entry.first     = (digit_index == 4'd0);
    entry.tenth     = (digit_index == 4'd9);
    entry.digit     = d;
    entry.p1        = mod11(7'(d * w1));
    entry.p2        = mod11(7'(d * w2));
    if (!in_range) begin
      entry.fmt_ok = 1'b1;
    end else if ((char_position == POS_DOT_A) || (char_position == POS_DOT_B)) begin
      entry.fmt_ok = (s_tdata == CHAR_DOT);
    end else if (char_position == POS_DASH) begin
      entry.fmt_ok = (s_tdata == CHAR_DASH);
    end else begin
      entry.fmt_ok = is_digit;
    end

    char_position_next = (char_position == POS_MAX) ? POS_MAX : char_position + 4'd1;
    if (entry.digit_pos && digit_index != 4'd15) begin
      digit_index_next = digit_index + 4'd1;
    end else begin
      digit_index_next = digit_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      digit_index   <= '0;
    end else if (push) begin
      if (s_tlast) begin
        char_position <= '0;
        digit_index   <= '0;
      end else begin
        char_position <= char_position_next;
        digit_index   <= digit_index_next;
      end
    end
  end

endmodule

>>> sv/cpfv_queue.sv
// Short queue of classified characters between the front and the back.
// Depends on cpfv_pkg.
module cpfv_queue import cpfv_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  class_t push_data,
  input  logic   pop,
  output logic   q_valid,
  output logic   q_full,
  output class_t q_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  class_t         mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign q_valid = (count != '0);
  assign q_full  = (count == CW'(DEPTH));
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> !pop) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

>>> sv/cpfv_back.sv
// Back part: keeps the mod-11 residues and the digit checks, and gives the
// verdict on the last character through an output register. Depends on cpfv_pkg.
module cpfv_back import cpfv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  class_t     q_data,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] valid_res, [3:1] error_code, [7:4] zero
);

  logic [3:0] r1;
  logic [3:0] r2;
  logic [3:0] leading;
  logic       all_eq;
  logic       fmt_bad;
  logic [3:0] tenth;
  logic       valid_res;
  err_t       error_code;

  logic [3:0] r1_next;
  logic [3:0] r2_next;
  logic [3:0] leading_next;
  logic       all_eq_next;
  logic       fmt_bad_next;
  logic [3:0] tenth_next;
  logic [3:0] final_digit;
  logic       good_digit;
  logic [4:0] sum1;
  logic [4:0] sum2;
  err_t       code;

  assign pop      = q_valid && (!q_data.last || !m_tvalid || m_tready);
  assign m_tdata  = {4'd0, error_code, valid_res};

  always_comb begin
    good_digit   = q_data.digit_pos && q_data.fmt_ok;
    sum1         = 5'(r1) + 5'(q_data.p1);
    sum2         = 5'(r2) + 5'(q_data.p2);
    r1_next      = r1;
    r2_next      = r2;
    leading_next = leading;
    all_eq_next  = all_eq;
    tenth_next   = tenth;
    fmt_bad_next = fmt_bad || !q_data.fmt_ok;
    final_digit  = good_digit ? q_data.digit : 4'd0;
    if (good_digit) begin
      r1_next = (sum1 >= 5'(MODULUS)) ? 4'(sum1 - 5'(MODULUS)) : sum1[3:0];
      r2_next = (sum2 >= 5'(MODULUS)) ? 4'(sum2 - 5'(MODULUS)) : sum2[3:0];
      if (q_data.first) begin
        leading_next = q_data.digit;
      end else if (q_data.digit != leading) begin
        all_eq_next = 1'b0;
      end
      if (q_data.tenth) begin
        tenth_next = q_data.digit;
      end
    end

    if (!q_data.len_ok) begin
      code = ERR_LENGTH;
    end else if (fmt_bad_next) begin
      code = ERR_FORMAT;
    end else if (all_eq_next) begin
      code = ERR_SAME;
    end else if (check_of(r1_next) != tenth_next) begin
      code = ERR_CHECK1;
    end else if (check_of(r2_next) != final_digit) begin
      code = ERR_CHECK2;
    end else begin
      code = ERR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1      <= '0;
      r2      <= '0;
      leading <= '0;
      all_eq  <= 1'b1;
      fmt_bad <= 1'b0;
      tenth   <= '0;
    end else if (pop) begin
      if (q_data.last) begin
        r1      <= '0;
        r2      <= '0;
        leading <= '0;
        all_eq  <= 1'b1;
        fmt_bad <= 1'b0;
        tenth   <= '0;
      end else begin
        r1      <= r1_next;
        r2      <= r2_next;
        leading <= leading_next;
        all_eq  <= all_eq_next;
        fmt_bad <= fmt_bad_next;
        tenth   <= tenth_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && q_data.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_data.last) begin
      valid_res  <= (code == ERR_OK);
      error_code <= code;
    end
  end

  a_verdict_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (valid_res == (error_code == ERR_OK)))
    else $error("verdict flag disagrees with error code");
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (pop && q_data.last) |=> (all_eq && !fmt_bad && r1 == 4'd0 && r2 == 4'd0))
    else $error("state not cleared after verdict");
  a_residue_range: assert property (@(posedge clk) disable iff (rst)
    (r1 < MODULUS) && (r2 < MODULUS)) else $error("residue out of range");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(pop && q_data.last))
    else $error("pending verdict overwritten");

endmodule
